### hdl/slsfr_pkg.sv
// Package with the shared types and constants of the sync-word frame receiver.
package slsfr_pkg;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_CMD     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SUMHI   = 3'd5,
    PH_SUMLO   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CSUM    = 2'd2,
    KIND_HEADER  = 2'd3
  } kind_t;

  // Register select: word address bit 2 picks the register.
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hEE;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } sync_cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic [7:0]  byte_index;
    logic [15:0] computed_sum;
  } result_t;

endpackage

### hdl/slsfr_cfg.sv
// APB-style register file holding the two expected sync bytes.
module slsfr_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output slsfr_pkg::sync_cfg_t cfg
);

  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slsfr_pkg::SYNC_FIRST_RST;
      sync_second_r <= slsfr_pkg::SYNC_SECOND_RST;
    end else if (wr_en) begin
      case (paddr[2])
        slsfr_pkg::REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        slsfr_pkg::REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      slsfr_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      slsfr_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg.sync_first  = sync_first_r;
  assign cfg.sync_second = sync_second_r;

endmodule

### hdl/slsfr_parser.sv
// Frame parser: phase state, running sum and the result of one byte.
module slsfr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [7:0]           byte_value,
  input  logic                 chunk_end,
  input  slsfr_pkg::sync_cfg_t cfg,
  output logic                 res_valid,
  output slsfr_pkg::result_t   res
);

  slsfr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic        discard_r, discard_nxt;
  logic [15:0] sum_add;
  logic [7:0]  cnt_inc;

  assign sum_add = sum_r + {8'd0, byte_value};
  assign cnt_inc = cnt_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= slsfr_pkg::PH_SYNC1;
      sum_r     <= '0;
      len_r     <= '0;
      cmd_r     <= '0;
      cnt_r     <= '0;
      sum_hi_r  <= '0;
      discard_r <= 1'b0;
    end else if (go) begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      len_r     <= len_nxt;
      cmd_r     <= cmd_nxt;
      cnt_r     <= cnt_nxt;
      sum_hi_r  <= sum_hi_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    cmd_nxt     = cmd_r;
    cnt_nxt     = cnt_r;
    sum_hi_nxt  = sum_hi_r;
    discard_nxt = discard_r;
    res_valid   = 1'b0;
    res         = '0;
    res.kind    = slsfr_pkg::KIND_HEADER;

    if (!discard_r) begin
      case (phase_r)
        slsfr_pkg::PH_SYNC1: begin
          if (byte_value == cfg.sync_first) begin
            sum_nxt    = {8'd0, byte_value};
            len_nxt    = '0;
            cmd_nxt    = '0;
            cnt_nxt    = '0;
            sum_hi_nxt = '0;
            phase_nxt  = slsfr_pkg::PH_SYNC2;
          end else begin
            res_valid   = 1'b1;
            discard_nxt = 1'b1;
          end
        end
        slsfr_pkg::PH_SYNC2: begin
          if (byte_value == cfg.sync_second) begin
            sum_nxt   = sum_add;
            phase_nxt = slsfr_pkg::PH_LEN;
          end else begin
            res_valid   = 1'b1;
            discard_nxt = 1'b1;
            phase_nxt   = slsfr_pkg::PH_SYNC1;
          end
        end
        slsfr_pkg::PH_LEN: begin
          len_nxt   = byte_value;
          sum_nxt   = sum_add;
          phase_nxt = slsfr_pkg::PH_CMD;
        end
        slsfr_pkg::PH_CMD: begin
          cmd_nxt   = byte_value;
          sum_nxt   = sum_add;
          cnt_nxt   = '0;
          phase_nxt = (len_r == 8'd0) ? slsfr_pkg::PH_SUMHI : slsfr_pkg::PH_PAYLOAD;
        end
        slsfr_pkg::PH_PAYLOAD: begin
          sum_nxt                = sum_add;
          res_valid              = 1'b1;
          res.kind               = slsfr_pkg::KIND_PAYLOAD;
          res.data_byte          = byte_value;
          res.command            = cmd_r;
          res.payload_length     = len_r;
          res.byte_index         = cnt_r;
          res.computed_sum       = sum_add;
          cnt_nxt                = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = slsfr_pkg::PH_SUMHI;
          end
        end
        slsfr_pkg::PH_SUMHI: begin
          sum_hi_nxt = byte_value;
          phase_nxt  = slsfr_pkg::PH_SUMLO;
        end
        slsfr_pkg::PH_SUMLO: begin
          res_valid          = 1'b1;
          res.kind           = ({sum_hi_r, byte_value} == sum_r) ?
                               slsfr_pkg::KIND_GOOD : slsfr_pkg::KIND_CSUM;
          res.command        = cmd_r;
          res.payload_length = len_r;
          res.computed_sum   = sum_r;
          phase_nxt          = slsfr_pkg::PH_SYNC1;
        end
        default: begin
          phase_nxt = slsfr_pkg::PH_SYNC1;
        end
      endcase
    end

    // The end of a chunk drops any partial frame after this byte is handled.
    if (chunk_end) begin
      phase_nxt   = slsfr_pkg::PH_SYNC1;
      sum_nxt     = '0;
      len_nxt     = '0;
      cmd_nxt     = '0;
      cnt_nxt     = '0;
      sum_hi_nxt  = '0;
      discard_nxt = 1'b0;
    end
  end

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    go && discard_r |-> !res_valid)
    else $error("result produced while dropping the rest of a chunk");

  a_chunk_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && chunk_end |=> phase_r == slsfr_pkg::PH_SYNC1 && !discard_r && sum_r == 16'd0)
    else $error("parser did not restart after chunk end");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == slsfr_pkg::PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload count reached frame length inside payload");

  a_discard_at_sync1: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> phase_r == slsfr_pkg::PH_SYNC1)
    else $error("dropping bytes outside the sync search phase");

endmodule

### hdl/sync_len_sum16_frame_receiver.sv
// Sync-word frame receiver. Each byte item passes an input register, the frame
// parser and an output register, so an item is accepted in every cycle while no
// result waits on out_ready; only bytes that yield a result raise out_valid. The
// parser state registers set the rate of one byte per cycle. A result that waits
// on out_ready stalls the parser; the input register then takes an item only while
// it is empty. The sync bytes are to be written through the APB port at addresses
// 0 and 4 only while no item is in flight; the block itself does not enforce this.
module sync_len_sum16_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_chunk_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_command,
  output logic [7:0]  out_payload_length,
  output logic [7:0]  out_byte_index,
  output logic [15:0] out_computed_sum,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  slsfr_pkg::sync_cfg_t cfg;
  slsfr_pkg::result_t   res;
  slsfr_pkg::result_t   res_r;
  logic                 res_valid;
  logic                 in_valid_r;
  logic [7:0]           byte_r;
  logic                 last_r;
  logic                 out_valid_r;
  logic                 go;

  // The held byte is parsed when the output register is free or being emptied.
  assign go       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte_value;
      last_r <= in_chunk_end;
    end
  end

  slsfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slsfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .byte_value (byte_r),
    .chunk_end  (last_r),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_data_byte      = res_r.data_byte;
  assign out_command        = res_r.command;
  assign out_payload_length = res_r.payload_length;
  assign out_byte_index     = res_r.byte_index;
  assign out_computed_sum   = res_r.computed_sum;

endmodule

### bench/testbench.sv
// Self-checking bench for the sync-word frame receiver: byte items in, results checked.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_chunk_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_command;
  logic [7:0]  out_payload_length;
  logic [7:0]  out_byte_index;
  logic [15:0] out_computed_sum;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  sync_len_sum16_frame_receiver uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte_value(in_byte_value),
    .in_chunk_end(in_chunk_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_command(out_command),
    .out_payload_length(out_payload_length),
    .out_byte_index(out_byte_index),
    .out_computed_sum(out_computed_sum),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as the bench sees it.
  logic [7:0]          sync_first_reg = slsfr_pkg::SYNC_FIRST_RST;
  logic [7:0]          sync_second_reg = slsfr_pkg::SYNC_SECOND_RST;
  slsfr_pkg::phase_t   rx_phase = slsfr_pkg::PH_SYNC1;
  logic [15:0]         rx_sum = '0;
  logic [7:0]          rx_len = '0;
  logic [7:0]          rx_cmd = '0;
  logic [7:0]          rx_count = '0;
  logic [7:0]          rx_sum_hi = '0;
  bit                  rx_dropping = 1'b0;

  slsfr_pkg::result_t  expected_results[$];
  logic [7:0]          chunk_bytes[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  item_count = 0;
  int  kind_seen[4] = '{0, 0, 0, 0};
  bit  idle_on = 1'b0;
  bit  stall_on = 1'b0;
  int  stall_left = 0;

  // Advances the parser by one accepted byte and queues the result it causes.
  function automatic void parse_byte(logic [7:0] b, logic last);
    slsfr_pkg::result_t r;
    bit                 has_result;
    r = '0;
    has_result = 1'b0;
    if (!rx_dropping) begin
      case (rx_phase)
        slsfr_pkg::PH_SYNC1: begin
          if (b == sync_first_reg) begin
            rx_sum = {8'h00, b};
            rx_len = '0;
            rx_cmd = '0;
            rx_count = '0;
            rx_sum_hi = '0;
            rx_phase = slsfr_pkg::PH_SYNC2;
          end else begin
            r.kind = slsfr_pkg::KIND_HEADER;
            has_result = 1'b1;
            rx_dropping = 1'b1;
          end
        end
        slsfr_pkg::PH_SYNC2: begin
          if (b == sync_second_reg) begin
            rx_sum = rx_sum + {8'h00, b};
            rx_phase = slsfr_pkg::PH_LEN;
          end else begin
            r.kind = slsfr_pkg::KIND_HEADER;
            has_result = 1'b1;
            rx_dropping = 1'b1;
            rx_phase = slsfr_pkg::PH_SYNC1;
          end
        end
        slsfr_pkg::PH_LEN: begin
          rx_len = b;
          rx_sum = rx_sum + {8'h00, b};
          rx_phase = slsfr_pkg::PH_CMD;
        end
        slsfr_pkg::PH_CMD: begin
          rx_cmd = b;
          rx_sum = rx_sum + {8'h00, b};
          rx_count = '0;
          rx_phase = (rx_len == 8'd0) ? slsfr_pkg::PH_SUMHI : slsfr_pkg::PH_PAYLOAD;
        end
        slsfr_pkg::PH_PAYLOAD: begin
          rx_sum = rx_sum + {8'h00, b};
          r.kind = slsfr_pkg::KIND_PAYLOAD;
          r.data_byte = b;
          r.command = rx_cmd;
          r.payload_length = rx_len;
          r.byte_index = rx_count;
          r.computed_sum = rx_sum;
          has_result = 1'b1;
          rx_count = rx_count + 8'd1;
          if (rx_count == rx_len) rx_phase = slsfr_pkg::PH_SUMHI;
        end
        slsfr_pkg::PH_SUMHI: begin
          rx_sum_hi = b;
          rx_phase = slsfr_pkg::PH_SUMLO;
        end
        slsfr_pkg::PH_SUMLO: begin
          r.kind = ({rx_sum_hi, b} == rx_sum) ? slsfr_pkg::KIND_GOOD : slsfr_pkg::KIND_CSUM;
          r.command = rx_cmd;
          r.payload_length = rx_len;
          r.computed_sum = rx_sum;
          has_result = 1'b1;
          rx_phase = slsfr_pkg::PH_SYNC1;
        end
        default: rx_phase = slsfr_pkg::PH_SYNC1;
      endcase
    end
    if (has_result) expected_results.push_back(r);
    if (last) begin
      rx_phase = slsfr_pkg::PH_SYNC1;
      rx_sum = '0;
      rx_len = '0;
      rx_cmd = '0;
      rx_count = '0;
      rx_sum_hi = '0;
      rx_dropping = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker and run watchdog.
  always @(posedge clk) begin
    slsfr_pkg::result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, sum %0h", out_kind, out_computed_sum);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        kind_seen[want.kind]++;
        check_field("kind", 16'(want.kind), 16'(out_kind));
        check_field("data_byte", 16'(want.data_byte), 16'(out_data_byte));
        check_field("command", 16'(want.command), 16'(out_command));
        check_field("payload_length", 16'(want.payload_length),
                    16'(out_payload_length));
        check_field("byte_index", 16'(want.byte_index), 16'(out_byte_index));
        check_field("computed_sum", want.computed_sum, out_computed_sum);
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (stall_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
    out_ready <= (stall_left == 0);
  end

  // Called just after an acceptance edge (or at a negedge); presents one item.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_chunk_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b, last);
    item_count++;
  endtask

  task automatic send_chunk();
    int i;
    for (i = 0; i < chunk_bytes.size(); i++) begin
      send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
    end
    chunk_bytes.delete();
  endtask

  // Holds the sender until every result is in and the pipeline has emptied.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic sel, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {24'($urandom_range(0, 32'hFFFFFF)), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == slsfr_pkg::REG_SYNC_FIRST) sync_first_reg = value;
    else sync_second_reg = value;
    // Read the register back.
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("readback", 16'(value), 16'(prdata[7:0]));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    wait_idle();
    write_sync(slsfr_pkg::REG_SYNC_FIRST, first);
    write_sync(slsfr_pkg::REG_SYNC_SECOND, second);
  endtask

  // Appends one frame under the current sync setting, optionally with a broken sum.
  function automatic void append_frame(int len, bit bad_sum);
    logic [15:0] sum;
    logic [7:0]  v;
    int          i;
    chunk_bytes.push_back(sync_first_reg);
    chunk_bytes.push_back(sync_second_reg);
    chunk_bytes.push_back(len[7:0]);
    sum = 16'(sync_first_reg) + 16'(sync_second_reg) + 16'(len[7:0]);
    v = 8'($urandom_range(0, 255));
    chunk_bytes.push_back(v);
    sum = sum + 16'(v);
    for (i = 0; i < len; i++) begin
      v = 8'($urandom_range(0, 255));
      chunk_bytes.push_back(v);
      sum = sum + 16'(v);
    end
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    chunk_bytes.push_back(sum[15:8]);
    chunk_bytes.push_back(sum[7:0]);
  endfunction

  function automatic int random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 90) return $urandom_range(0, 12);
    else if (pick < 98) return $urandom_range(13, 60);
    return $urandom_range(200, 255);
  endfunction

  // One chunk: mostly back-to-back good frames, with bad sums, header faults,
  // cut-short frames and pure noise mixed in.
  task automatic random_chunk();
    int          frames;
    int          i;
    int          pick;
    int          cut;
    logic [7:0]  v;
    frames = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) chunk_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < frames; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          v = 8'($urandom_range(0, 255));
          while (v == sync_first_reg) v = 8'($urandom_range(0, 255));
          chunk_bytes.push_back(v);
          repeat ($urandom_range(0, 5)) chunk_bytes.push_back(8'($urandom_range(0, 255)));
          break;
        end else if (pick < 10) begin
          chunk_bytes.push_back(sync_first_reg);
          v = 8'($urandom_range(0, 255));
          while (v == sync_second_reg) v = 8'($urandom_range(0, 255));
          chunk_bytes.push_back(v);
          repeat ($urandom_range(0, 5)) chunk_bytes.push_back(8'($urandom_range(0, 255)));
          break;
        end else begin
          append_frame(random_length(), $urandom_range(0, 4) == 0);
        end
      end
      if (chunk_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, chunk_bytes.size() - 1);
        repeat (cut) void'(chunk_bytes.pop_back());
      end
    end
    send_chunk();
  endtask

  task automatic run_random_phase(input int n_items, input bit with_longest);
    int stop_at;
    stop_at = item_count + n_items;
    if (with_longest) begin
      append_frame(255, 1'b0);
      send_chunk();
    end
    while (item_count < stop_at) random_chunk();
  endtask

  // Two back-to-back frames at the reset sync values: empty payload with a good
  // sum, then one 0xFF payload byte with a wrong sum.
  task automatic test_reset_frames();
    send_byte(8'h55, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Bad first sync drops the rest of the chunk; bad second sync on the chunk end.
  task automatic test_header_errors();
    send_byte(8'h12, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h11, 1'b1);
  endtask

  // Chunk end in the payload: the marked byte is still reported.
  task automatic test_chunk_cut();
    send_byte(8'h55, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_sync_extremes();
    set_sync(8'h00, 8'hFF);
    run_random_phase(350, 1'b1);
    set_sync(8'hFF, 8'h00);
    run_random_phase(350, 1'b0);
  endtask

  task automatic test_random_sync_values();
    logic [7:0] v;
    set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random_phase(175, 1'b0);
    wait_idle();
    run_random_phase(175, 1'b0);
    v = 8'($urandom_range(0, 255));
    set_sync(v, v);
    run_random_phase(350, 1'b0);
  endtask

  // Full rate on both sides, back at the reset sync values.
  task automatic test_steady_stream();
    set_sync(slsfr_pkg::SYNC_FIRST_RST, slsfr_pkg::SYNC_SECOND_RST);
    idle_on = 1'b0;
    stall_on = 1'b0;
    run_random_phase(300, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    stall_on = 1'b1;
    test_reset_frames();
    test_header_errors();
    test_chunk_cut();
    test_sync_extremes();
    test_random_sync_values();
    test_steady_stream();
    wait_idle();
    $display("Sent %0d byte items over six sync settings; checked %0d payload bytes,",
             item_count, kind_seen[slsfr_pkg::KIND_PAYLOAD]);
    $display("%0d good frames, %0d checksum errors and %0d header errors.",
             kind_seen[slsfr_pkg::KIND_GOOD], kind_seen[slsfr_pkg::KIND_CSUM],
             kind_seen[slsfr_pkg::KIND_HEADER]);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
